@@ sv/bmm_pkg.sv @@
package bmm_pkg;

   localparam int MAX_LEFT  = 256;
   localparam int MAX_RIGHT = 256;
   localparam int MAX_EDGES = 4096;

   localparam int LW = $clog2(MAX_LEFT);     // left vertex index
   localparam int RW = $clog2(MAX_RIGHT);    // right vertex index
   localparam int EW = $clog2(MAX_EDGES);    // edge index
   localparam int LNW = LW + 1;              // left count / stack pointer
   localparam int RNW = RW + 1;
   localparam int ENW = EW + 1;              // edge index with nil
   localparam int LAYW = LW + 1;             // layer, all ones = no layer
   localparam int CW = 9;                    // count registers, match count

   localparam logic [ENW-1:0]  EDGE_NIL = ENW'(MAX_EDGES);
   localparam logic [LAYW-1:0] NO_LAYER = '1;
   localparam logic [LNW-1:0]  LEFT_CAP = LNW'(MAX_LEFT);
   // partner field of an unmatched right vertex, above every left index
   localparam logic [LNW-1:0]  RIGHT_FREE = LNW'(MAX_LEFT);

   // clearing pass after reset covers the deeper of the per-vertex memories
   localparam int CLR_DEPTH = (MAX_LEFT > MAX_RIGHT) ? MAX_LEFT : MAX_RIGHT;
   localparam int CLRW      = $clog2(CLR_DEPTH) + 1;

   localparam int EDGE_DW  = RW + ENW;        // target, link
   localparam int STACK_DW = LW + ENW + RW;   // vertex, next edge, target

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   localparam logic CSR_LEFT_COUNT  = 1'b0;
   localparam logic CSR_RIGHT_COUNT = 1'b1;

   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_RUN = 1'b1;

endpackage

@@ sv/bipartite_max_matching.sv @@
// Edge add: the request is taken in S_IDLE, the edge is written in S_ADD and
// the response is registered from S_DONE; the next request waits for S_IDLE.
// Run: data dependent; each phase seeds layers over the left vertices, builds
// the layering edge by edge from the queue of vertices, then scans the left
// vertices as roots, searches edge by edge and walks each path step by step.
// Reset (synchronous): a clearing pass empties the edge lists and the matching
// before the first request is taken. Counts reset to 256.
module bipartite_max_matching
   import bmm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_type,
   input  logic [7:0]    req_left_vertex,
   input  logic [7:0]    req_right_vertex,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [CW-1:0] rsp_match_count,
   output logic [1:0]    rsp_status,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [CW-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ADD, S_RSTART, S_BINIT, S_BINIT2, S_BPOP, S_BU, S_BU2,
      S_BEDGE, S_BV, S_BNX, S_BL, S_ANEXT, S_AROOT, S_AEDGE, S_APOP, S_AV,
      S_ANX, S_AL, S_APUSH, S_AAUG, S_AAUGW, S_DONE
   } state_type;

   state_type state_ff;

   logic [CW-1:0]    left_count_ff, right_count_ff;
   logic [ENW-1:0]   edge_total_ff;
   logic [CLRW-1:0]  clr_ff;

   logic [LW-1:0]    lv_ff;
   logic [RW-1:0]    rv_ff;
   logic             ok_ff;
   logic [1:0]       res_status_ff;
   logic [CW-1:0]    res_count_ff;
   logic             rsp_valid_ff;
   logic [CW-1:0]    rsp_count_ff;
   logic [1:0]       rsp_status_ff;

   logic [LNW-1:0]   nl_ff;
   logic [RNW-1:0]   nr_ff;
   logic [LNW-1:0]   i_ff, qh_ff, qt_ff, sp_ff, k_ff;
   logic [CW-1:0]    total_ff, got_ff;
   logic             found_ff;
   logic [LW-1:0]    u_ff, nx_ff;
   logic [ENW-1:0]   e_ff, link_ff;
   logic [LAYW-1:0]  lay_ff;
   logic [RW-1:0]    v_ff;

   // memory ports
   logic             edge_we;
   logic [EW-1:0]    edge_waddr, edge_raddr;
   logic [EDGE_DW-1:0] edge_wdata, edge_rdata;
   logic             head_we;
   logic [LW-1:0]    head_waddr, head_raddr;
   logic [ENW-1:0]   head_wdata, head_rdata;
   logic             rp_we;
   logic [RW-1:0]    rp_waddr, rp_raddr;
   logic [LNW-1:0]   rp_wdata, rp_rdata;
   logic             lp_we;
   logic [LW-1:0]    lp_waddr, lp_raddr;
   logic             lp_wdata, lp_rdata;
   logic             lay_we;
   logic [LW-1:0]    lay_waddr, lay_raddr;
   logic [LAYW-1:0]  lay_wdata, lay_rdata;
   logic             q_we;
   logic [LW-1:0]    q_waddr, q_raddr;
   logic [LW-1:0]    q_wdata, q_rdata;
   logic             st_we;
   logic [LW-1:0]    st_waddr, st_raddr;
   logic [STACK_DW-1:0] st_wdata, st_rdata;

   logic [RW-1:0]    ed_v;
   logic [ENW-1:0]   ed_link;
   logic [LW-1:0]    st_u;
   logic [ENW-1:0]   st_link;
   logic [RW-1:0]    st_v;
   logic [LNW-1:0]   eff_left;
   logic [RNW-1:0]   eff_right;
   logic [CW:0]      sum_wide;

   assign ed_v    = edge_rdata[EDGE_DW-1 -: RW];
   assign ed_link = edge_rdata[ENW-1:0];
   assign st_u    = st_rdata[STACK_DW-1 -: LW];
   assign st_link = st_rdata[RW +: ENW];
   assign st_v    = st_rdata[RW-1:0];

   assign eff_left  = (left_count_ff > CW'(MAX_LEFT)) ? LNW'(MAX_LEFT)
                                                      : LNW'(left_count_ff);
   assign eff_right = (right_count_ff > CW'(MAX_RIGHT)) ? RNW'(MAX_RIGHT)
                                                        : RNW'(right_count_ff);
   assign sum_wide  = {1'b0, total_ff} + {1'b0, got_ff};

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   bmm_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .raddr(edge_raddr), .rdata(edge_rdata));
   bmm_ram #(.WIDTH(ENW), .DEPTH(MAX_LEFT)) u_head (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));
   bmm_ram #(.WIDTH(LNW), .DEPTH(MAX_RIGHT)) u_rpart (
      .clock(clock), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
      .raddr(rp_raddr), .rdata(rp_rdata));
   bmm_ram #(.WIDTH(1), .DEPTH(MAX_LEFT)) u_lmatched (
      .clock(clock), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
      .raddr(lp_raddr), .rdata(lp_rdata));
   bmm_ram #(.WIDTH(LAYW), .DEPTH(MAX_LEFT)) u_layer (
      .clock(clock), .we(lay_we), .waddr(lay_waddr), .wdata(lay_wdata),
      .raddr(lay_raddr), .rdata(lay_rdata));
   bmm_ram #(.WIDTH(LW), .DEPTH(MAX_LEFT)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));
   bmm_ram #(.WIDTH(STACK_DW), .DEPTH(MAX_LEFT)) u_stack (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(st_raddr), .rdata(st_rdata));

   // memory address and write control
   always_comb begin
      edge_we    = 1'b0;
      edge_waddr = edge_total_ff[EW-1:0];
      edge_wdata = {rv_ff, head_rdata};
      edge_raddr = e_ff[EW-1:0];
      head_we    = 1'b0;
      head_waddr = lv_ff;
      head_wdata = edge_total_ff;
      head_raddr = req_left_vertex;
      rp_we      = 1'b0;
      rp_waddr   = v_ff;
      rp_wdata   = {1'b0, u_ff};
      rp_raddr   = ed_v;
      lp_we      = 1'b0;
      lp_waddr   = u_ff;
      lp_wdata   = 1'b1;
      lp_raddr   = i_ff[LW-1:0];
      lay_we     = 1'b0;
      lay_waddr  = i_ff[LW-1:0];
      lay_wdata  = NO_LAYER;
      lay_raddr  = rp_rdata[LW-1:0];
      q_we       = 1'b0;
      q_waddr    = qt_ff[LW-1:0];
      q_wdata    = i_ff[LW-1:0];
      q_raddr    = qh_ff[LW-1:0];
      st_we      = 1'b0;
      st_waddr   = sp_ff[LW-1:0] - LW'(1);
      st_wdata   = {u_ff, link_ff, v_ff};
      st_raddr   = sp_ff[LW-1:0] - LW'(2);
      case (state_ff)
         S_CLEAR: begin
            head_we    = (clr_ff < CLRW'(MAX_LEFT));
            head_waddr = clr_ff[LW-1:0];
            head_wdata = EDGE_NIL;
            rp_we      = (clr_ff < CLRW'(MAX_RIGHT));
            rp_waddr   = clr_ff[RW-1:0];
            rp_wdata   = RIGHT_FREE;
            lp_we      = (clr_ff < CLRW'(MAX_LEFT));
            lp_waddr   = clr_ff[LW-1:0];
            lp_wdata   = 1'b0;
         end
         S_ADD: begin
            edge_we = ok_ff;
            head_we = ok_ff;
         end
         S_BINIT2: begin
            lay_we    = 1'b1;
            lay_wdata = lp_rdata ? NO_LAYER : '0;
            q_we      = !lp_rdata;
         end
         S_BU: begin
            head_raddr = q_rdata;
            lay_raddr  = q_rdata;
         end
         S_BL: begin
            if (lay_rdata == NO_LAYER && qt_ff < LEFT_CAP) begin
               lay_we    = 1'b1;
               lay_waddr = nx_ff;
               lay_wdata = lay_ff + LAYW'(1);
               q_we      = 1'b1;
               q_wdata   = nx_ff;
            end
         end
         S_ANEXT: head_raddr = i_ff[LW-1:0];
         S_AEDGE: begin
            if (e_ff == EDGE_NIL) begin
               lay_we    = 1'b1;
               lay_waddr = u_ff;
            end
         end
         S_ANX: begin
            if (rp_rdata == RIGHT_FREE) begin
               rp_we = 1'b1;
               lp_we = 1'b1;
            end
         end
         S_AL: begin
            head_raddr = nx_ff;
            st_we = (lay_rdata == lay_ff + LAYW'(1)) && (sp_ff < LEFT_CAP);
         end
         S_AAUG: st_raddr = k_ff[LW-1:0] - LW'(1);
         S_AAUGW: begin
            rp_we    = 1'b1;
            rp_waddr = st_v;
            rp_wdata = {1'b0, st_u};
            lp_we    = 1'b1;
            lp_waddr = st_u;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         left_count_ff  <= CW'(256);
         right_count_ff <= CW'(256);
         edge_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LEFT_COUNT) begin
               left_count_ff <= csr_wdata;
            end else begin
               right_count_ff <= csr_wdata;
            end
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CLRW'(1);
               if (clr_ff == CLRW'(CLR_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  lv_ff <= req_left_vertex;
                  rv_ff <= req_right_vertex;
                  res_count_ff <= '0;
                  if (req_type == REQ_RUN) begin
                     state_ff <= S_RSTART;
                  end else begin
                     if ({1'b0, req_left_vertex} >= eff_left ||
                         {1'b0, req_right_vertex} >= eff_right) begin
                        ok_ff <= 1'b0;
                        res_status_ff <= ST_RANGE;
                     end else if (edge_total_ff == ENW'(MAX_EDGES)) begin
                        ok_ff <= 1'b0;
                        res_status_ff <= ST_FULL;
                     end else begin
                        ok_ff <= 1'b1;
                        res_status_ff <= ST_OK;
                     end
                     state_ff <= S_ADD;
                  end
               end
            end
            S_ADD: begin
               if (ok_ff) begin
                  edge_total_ff <= edge_total_ff + ENW'(1);
               end
               state_ff <= S_DONE;
            end
            S_RSTART: begin
               nl_ff <= eff_left;
               nr_ff <= eff_right;
               total_ff <= '0;
               res_status_ff <= ST_OK;
               i_ff <= '0;
               qt_ff <= '0;
               found_ff <= 1'b0;
               state_ff <= S_BINIT;
            end
            S_BINIT: begin
               if (i_ff < nl_ff) begin
                  state_ff <= S_BINIT2;
               end else begin
                  qh_ff <= '0;
                  state_ff <= S_BPOP;
               end
            end
            S_BINIT2: begin
               if (!lp_rdata) begin
                  qt_ff <= qt_ff + LNW'(1);
               end
               i_ff <= i_ff + LNW'(1);
               state_ff <= S_BINIT;
            end
            S_BPOP: begin
               if (qh_ff < qt_ff) begin
                  qh_ff <= qh_ff + LNW'(1);
                  state_ff <= S_BU;
               end else if (found_ff) begin
                  i_ff <= '0;
                  got_ff <= '0;
                  state_ff <= S_ANEXT;
               end else begin
                  res_count_ff <= total_ff;
                  state_ff <= S_DONE;
               end
            end
            S_BU: begin
               u_ff <= q_rdata;
               state_ff <= S_BU2;
            end
            S_BU2: begin
               e_ff <= head_rdata;
               lay_ff <= lay_rdata;
               state_ff <= S_BEDGE;
            end
            S_BEDGE: begin
               state_ff <= (e_ff == EDGE_NIL) ? S_BPOP : S_BV;
            end
            S_BV: begin
               e_ff <= ed_link;
               state_ff <= ({1'b0, ed_v} < nr_ff) ? S_BNX : S_BEDGE;
            end
            S_BNX: begin
               if (rp_rdata == RIGHT_FREE) begin
                  found_ff <= 1'b1;
                  state_ff <= S_BEDGE;
               end else begin
                  nx_ff <= rp_rdata[LW-1:0];
                  state_ff <= (rp_rdata < nl_ff) ? S_BL : S_BEDGE;
               end
            end
            S_BL: begin
               if (lay_rdata == NO_LAYER && qt_ff < LEFT_CAP) begin
                  qt_ff <= qt_ff + LNW'(1);
               end
               state_ff <= S_BEDGE;
            end
            S_ANEXT: begin
               if (i_ff >= nl_ff) begin
                  if (got_ff == '0) begin
                     res_count_ff <= total_ff;
                     state_ff <= S_DONE;
                  end else begin
                     total_ff <= sum_wide[CW] ? '1 : sum_wide[CW-1:0];
                     i_ff <= '0;
                     qt_ff <= '0;
                     found_ff <= 1'b0;
                     state_ff <= S_BINIT;
                  end
               end else begin
                  state_ff <= S_AROOT;
               end
            end
            S_AROOT: begin
               if (lp_rdata) begin
                  i_ff <= i_ff + LNW'(1);
                  state_ff <= S_ANEXT;
               end else begin
                  u_ff <= i_ff[LW-1:0];
                  e_ff <= head_rdata;
                  lay_ff <= '0;
                  sp_ff <= LNW'(1);
                  state_ff <= S_AEDGE;
               end
            end
            S_AEDGE: begin
               if (e_ff == EDGE_NIL) begin
                  if (sp_ff == LNW'(1)) begin
                     i_ff <= i_ff + LNW'(1);
                     state_ff <= S_ANEXT;
                  end else begin
                     sp_ff <= sp_ff - LNW'(1);
                     state_ff <= S_APOP;
                  end
               end else begin
                  state_ff <= S_AV;
               end
            end
            S_APOP: begin
               u_ff <= st_u;
               e_ff <= st_link;
               lay_ff <= lay_ff - LAYW'(1);
               state_ff <= S_AEDGE;
            end
            S_AV: begin
               v_ff <= ed_v;
               link_ff <= ed_link;
               if ({1'b0, ed_v} >= nr_ff) begin
                  e_ff <= ed_link;
                  state_ff <= S_AEDGE;
               end else begin
                  state_ff <= S_ANX;
               end
            end
            S_ANX: begin
               if (rp_rdata == RIGHT_FREE) begin
                  k_ff <= sp_ff - LNW'(1);
                  state_ff <= S_AAUG;
               end else begin
                  nx_ff <= rp_rdata[LW-1:0];
                  if (rp_rdata < nl_ff) begin
                     state_ff <= S_AL;
                  end else begin
                     e_ff <= link_ff;
                     state_ff <= S_AEDGE;
                  end
               end
            end
            S_AL: begin
               if (lay_rdata == lay_ff + LAYW'(1) && sp_ff < LEFT_CAP) begin
                  state_ff <= S_APUSH;
               end else begin
                  e_ff <= link_ff;
                  state_ff <= S_AEDGE;
               end
            end
            S_APUSH: begin
               u_ff <= nx_ff;
               e_ff <= head_rdata;
               lay_ff <= lay_ff + LAYW'(1);
               sp_ff <= sp_ff + LNW'(1);
               state_ff <= S_AEDGE;
            end
            S_AAUG: begin
               if (k_ff == '0) begin
                  got_ff <= got_ff + CW'(1);
                  i_ff <= i_ff + LNW'(1);
                  state_ff <= S_ANEXT;
               end else begin
                  k_ff <= k_ff - LNW'(1);
                  state_ff <= S_AAUGW;
               end
            end
            S_AAUGW: begin
               state_ff <= S_AAUG;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_count_ff  <= res_count_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ sv/bmm_ram.sv @@
module bmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ sv/bmm_checker.sv @@
module bmm_checker
   import bmm_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [CW-1:0] rsp_match_count,
   input logic [1:0]    rsp_status
);

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count)
                                  && $stable(rsp_status))
      else $error("response changed while stalled");

   // one request in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");

   // a dropped edge never reports a count
   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_match_count == '0)
      else $error("count on error response");

endmodule

bind bipartite_max_matching bmm_checker u_bmm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_match_count(rsp_match_count), .rsp_status(rsp_status));
